FILE: design/counting_semaphore_fifo_waiters_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the counting semaphore block
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH

// same-cycle implication
`define CSFW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/csfw_pkg.sv
// ---------------------------------------------------------------------------
// csfw_pkg
// Types, codes and sizing constants of the counting semaphore block.
// ---------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

	localparam int MAX_THREADS = 16;
	localparam int COUNT_WIDTH = 8;
	localparam int TID_W       = 4;
	localparam int INIT_W      = 8;
	localparam int PTR_W       = $clog2(MAX_THREADS);
	localparam int TOT_W       = $clog2(MAX_THREADS + 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [TOT_W-1:0]       total_t;
	typedef logic [TID_W-1:0]       tid_t;
	typedef logic [INIT_W-1:0]      init_t;

	localparam count_t COUNT_MAX = '1;
	localparam total_t TOTAL_FULL = TOT_W'(MAX_THREADS);
	localparam ptr_t   PTR_LAST   = PTR_W'(MAX_THREADS - 1);
	localparam init_t  INIT_RESET = INIT_W'(1);

	typedef enum logic [1:0] {
		OP_DOWN    = 2'd0,
		OP_POLL    = 2'd1,
		OP_UP      = 2'd2,
		OP_DESTROY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_UNAVAIL   = 3'd1,
		ST_QUEUED    = 3'd2,
		ST_DEAD      = 3'd3,
		ST_MISMATCH  = 3'd4,
		ST_FULL      = 3'd5,
		ST_SATURATED = 3'd6
	} status_t;

	typedef struct packed {
		op_t  opcode;
		tid_t thread_id;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    wake_valid;
		tid_t    wake_thread;
	} rsp_t;

	// clamp the written initial count to the count range
	function automatic count_t sat_count(input init_t v);
		logic [39:0] wide;
		wide = 40'(v);
		if (wide > 40'(COUNT_MAX))
			return COUNT_MAX;
		else
			return count_t'(wide);
	endfunction

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

`default_nettype wire

FILE: design/csfw_ram.sv
// ---------------------------------------------------------------------------
// csfw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module csfw_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/counting_semaphore_fifo_waiters_top.sv
// A result strobes on done once the start transaction has passed valid_s1 and done_q.
// A new request is taken only while busy is low; the waiter RAM read of the head
//   entry happens at accept, the count/queue update in the valid_s1 stage.
// busy is high in the cycle after an accepted start; results cannot stall.
// Reset (arst_n low, asynchronous): count = 1, queue empty, not destroyed,
//   initial count register = 1. No clearing pass; the waiter RAM is not reset.
// ---------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top
// Counting semaphore with a FIFO of waiting thread ids held in a RAM.
// ---------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_fifo_waiters_top_defines.svh"

module counting_semaphore_fifo_waiters_top
	import csfw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire req_t  req,
	output logic       done,
	output rsp_t       rsp,
	input  wire logic  cfg_we,
	input  wire init_t cfg_wdata
);

	logic   valid_s1;
	req_t   req_s1;
	count_t count_q;
	logic   dead_q;
	ptr_t   head_q;
	ptr_t   tail_q;
	total_t total_q;
	init_t  init_q;
	logic   done_q;
	rsp_t   rsp_q;

	logic   accept;
	tid_t   head_tid;
	logic   avail;
	logic   push;
	logic   pop;
	rsp_t   rsp_d;
	count_t count_d;
	logic   dead_d;

	assign accept = start && !busy;
	assign busy   = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

	// head entry is read at accept; head_q holds until the update edge
	csfw_ram #(
		.DEPTH(MAX_THREADS),
		.WIDTH(TID_W)
	) u_wait_ram (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(req_s1.thread_id),
		.re   (accept),
		.raddr(head_q),
		.rdata(head_tid)
	);

	assign avail = (count_q != '0) && (total_q == '0);

	always_comb begin
		rsp_d   = '{status: ST_DONE, wake_valid: 1'b0, wake_thread: '0};
		count_d = count_q;
		dead_d  = dead_q;
		push    = 1'b0;
		pop     = 1'b0;
		if (valid_s1) begin
			if (dead_q) begin
				rsp_d.status = ST_DEAD;
			end else begin
				unique case (req_s1.opcode)
					OP_DOWN: begin
						if (avail)
							count_d = count_q - 1'b1;
						else if (total_q == TOTAL_FULL)
							rsp_d.status = ST_FULL;
						else begin
							push         = 1'b1;
							rsp_d.status = ST_QUEUED;
						end
					end
					OP_POLL: begin
						if (avail)
							count_d = count_q - 1'b1;
						else
							rsp_d.status = ST_UNAVAIL;
					end
					OP_UP: begin
						if (total_q != '0) begin
							// hand the unit straight to the head waiter
							pop               = 1'b1;
							rsp_d.wake_valid  = 1'b1;
							rsp_d.wake_thread = head_tid;
						end else if (count_q == COUNT_MAX)
							rsp_d.status = ST_SATURATED;
						else
							count_d = count_q + 1'b1;
					end
					OP_DESTROY: begin
						dead_d = 1'b1;
						if (count_q != sat_count(init_q))
							rsp_d.status = ST_MISMATCH;
					end
					default: begin
						rsp_d.status = ST_DONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= sat_count(INIT_RESET);
			dead_q  <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
			init_q  <= INIT_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (cfg_we) begin
				// reload: drop the queue and the dead mark
				init_q  <= cfg_wdata;
				count_q <= sat_count(cfg_wdata);
				dead_q  <= 1'b0;
				head_q  <= '0;
				tail_q  <= '0;
				total_q <= '0;
			end else begin
				count_q <= count_d;
				dead_q  <= dead_d;
				if (push) begin
					tail_q  <= ptr_next(tail_q);
					total_q <= total_q + 1'b1;
				end
				if (pop) begin
					head_q  <= ptr_next(head_q);
					total_q <= total_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`CSFW_ASSERT_NEXT(a_start_busy, clk, arst_n, accept, busy && !done,
		"accepted transaction must raise busy")
	`CSFW_ASSERT_NEXT(a_one_result, clk, arst_n, valid_s1, done && !busy,
		"every transaction gives one result")
	`CSFW_ASSERT_NOW(a_wake_ok, clk, arst_n, done && rsp.wake_valid,
		rsp.status == ST_DONE, "wake must carry done status")
	`CSFW_ASSERT_NOW(a_wake_zero, clk, arst_n, done && !rsp.wake_valid,
		rsp.wake_thread == '0, "wake thread must be zero without wake")
	`CSFW_ASSERT_NOW(a_no_push_pop, clk, arst_n, push || pop,
		!(push && pop) && !cfg_we, "queue update collides")

endmodule

`default_nettype wire
